>>> rtl/bee_pkg.sv
// shared types, character codes and hex decode for the backslash escape expander
`timescale 1ns / 1ps
`default_nettype none
package bee_pkg;

   // escape decoder state
   typedef enum logic [1:0] {
      MODE_PLAIN = 2'd0,
      MODE_ESC   = 2'd1,
      MODE_HEX0  = 2'd2,
      MODE_HEX1  = 2'd3
   } mode_type;

   // one result item held in the output buffer
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       text_done;
   } res_type;

   // result of a hex digit lookup
   typedef struct packed {
      logic       valid;
      logic [3:0] nibble;
   } hex_type;

   localparam logic [7:0] CHR_BSLASH = 8'h5C;
   localparam logic [7:0] CHR_N      = 8'h6E;
   localparam logic [7:0] CHR_R      = 8'h72;
   localparam logic [7:0] CHR_T      = 8'h74;
   localparam logic [7:0] CHR_X      = 8'h78;
   localparam logic [7:0] CHR_ZERO   = 8'h30;
   localparam logic [7:0] CHR_NINE   = 8'h39;
   localparam logic [7:0] CHR_LA     = 8'h61;
   localparam logic [7:0] CHR_LF     = 8'h66;
   localparam logic [7:0] CHR_UA     = 8'h41;
   localparam logic [7:0] CHR_UF     = 8'h46;
   localparam logic [7:0] CHR_NL     = 8'h0A;
   localparam logic [7:0] CHR_CR     = 8'h0D;
   localparam logic [7:0] CHR_TAB    = 8'h09;
   localparam logic [7:0] CHR_NUL    = 8'h00;

   // ascii hex digit to nibble
   function automatic hex_type hex_decode(input logic [7:0] b);
      hex_type h;
      h.valid  = 1'b0;
      h.nibble = 4'd0;
      if (b >= CHR_ZERO && b <= CHR_NINE) begin
         h.valid  = 1'b1;
         h.nibble = b[3:0];
      end else if ((b >= CHR_LA && b <= CHR_LF) || (b >= CHR_UA && b <= CHR_UF)) begin
         // low nibble of 'a'..'f' and 'A'..'F' runs 1..6
         h.valid  = 1'b1;
         h.nibble = 4'(b[3:0] + 4'd9);
      end
      return h;
   endfunction

endpackage
`default_nettype wire

>>> rtl/backslash_escape_expander_top.sv
// backslash escape expander: decode logic, escape state and two-entry result buffer
// an item's first result is shown in the cycle after it is accepted
// throughput: one item per cycle while the output is not stalled and items give at
//   most one result each; an item that gives two results holds the input off until
//   the two-entry result buffer drains, one result per cycle while not stalled
// reset (synchronous, active high) returns to plain text mode, clears the hex
//   nibble and empties the result buffer
`timescale 1ns / 1ps
`default_nettype none
module backslash_escape_expander_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_text_end,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_run_last,
   output logic            rsp_text_done
);

   // escape state
   bee_pkg::mode_type mode_ff, mode_in;
   logic [3:0]        nib_ff, nib_in;

   // result buffer: slot0 is shown on the port, slot1 waits behind it
   bee_pkg::res_type  slot0_ff, slot0_in;
   bee_pkg::res_type  slot1_ff, slot1_in;
   logic [1:0]        count_ff, count_in;

   // decode outputs for the item on the input port
   logic [1:0]        n_res;
   logic [7:0]        byte0, byte1;
   bee_pkg::hex_type  hx;
   logic              pop, accept;
   logic [1:0]        count_left;

   // handshake: take an item only when the buffer will be empty after this cycle
   assign rsp_valid  = (count_ff != 2'd0);
   assign pop        = rsp_valid && !rsp_stall;
   assign count_left = count_ff - {1'b0, pop};
   assign req_stall  = (count_left != 2'd0);
   assign accept     = req_valid && !req_stall;

   assign rsp_out_byte  = slot0_ff.out_byte;
   assign rsp_run_last  = slot0_ff.run_last;
   assign rsp_text_done = slot0_ff.text_done;

   assign hx = bee_pkg::hex_decode(req_in_byte);

   // escape decode: results produced and next escape state
   always_comb begin
      mode_in = mode_ff;
      nib_in  = nib_ff;
      n_res   = 2'd0;
      byte0   = req_in_byte;
      byte1   = req_in_byte;
      case (mode_ff)
         bee_pkg::MODE_PLAIN: begin
            if (req_in_byte == bee_pkg::CHR_BSLASH && !req_text_end) begin
               mode_in = bee_pkg::MODE_ESC;
            end else begin
               n_res = 2'd1;
            end
         end
         bee_pkg::MODE_ESC: begin
            mode_in = bee_pkg::MODE_PLAIN;
            n_res   = 2'd1;
            case (req_in_byte)
               bee_pkg::CHR_N:      byte0 = bee_pkg::CHR_NL;
               bee_pkg::CHR_R:      byte0 = bee_pkg::CHR_CR;
               bee_pkg::CHR_T:      byte0 = bee_pkg::CHR_TAB;
               bee_pkg::CHR_ZERO:   byte0 = bee_pkg::CHR_NUL;
               bee_pkg::CHR_BSLASH: byte0 = bee_pkg::CHR_BSLASH;
               bee_pkg::CHR_X: begin
                  // \x at the end of the text just gives 'x'
                  if (!req_text_end) begin
                     mode_in = bee_pkg::MODE_HEX0;
                     n_res   = 2'd0;
                  end
               end
               default: begin
                  // unknown escape keeps the backslash
                  byte0 = bee_pkg::CHR_BSLASH;
                  n_res = 2'd2;
               end
            endcase
         end
         bee_pkg::MODE_HEX0: begin
            if (hx.valid) begin
               if (req_text_end) begin
                  mode_in = bee_pkg::MODE_PLAIN;
                  n_res   = 2'd1;
                  byte0   = {4'd0, hx.nibble};
               end else begin
                  nib_in  = hx.nibble;
                  mode_in = bee_pkg::MODE_HEX1;
               end
            end else begin
               // lone \x: 'x', then the byte as plain text, or a backslash starts a new escape
               byte0   = bee_pkg::CHR_X;
               mode_in = bee_pkg::MODE_PLAIN;
               if (req_in_byte == bee_pkg::CHR_BSLASH && !req_text_end) begin
                  mode_in = bee_pkg::MODE_ESC;
                  n_res   = 2'd1;
               end else begin
                  n_res = 2'd2;
               end
            end
         end
         bee_pkg::MODE_HEX1: begin
            mode_in = bee_pkg::MODE_PLAIN;
            if (hx.valid) begin
               n_res = 2'd1;
               byte0 = {nib_ff, hx.nibble};
            end else begin
               // single digit escape ends: its value, then the byte as plain text, or a backslash starts a new escape
               byte0 = {4'd0, nib_ff};
               if (req_in_byte == bee_pkg::CHR_BSLASH && !req_text_end) begin
                  mode_in = bee_pkg::MODE_ESC;
                  n_res   = 2'd1;
               end else begin
                  n_res = 2'd2;
               end
            end
         end
         default: begin
            mode_in = bee_pkg::MODE_PLAIN;
         end
      endcase
      // every text ends back in plain mode
      if (req_text_end) begin
         mode_in = bee_pkg::MODE_PLAIN;
      end
   end

   // result buffer next values
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_left;
      if (accept) begin
         count_in           = n_res;
         slot0_in.out_byte  = byte0;
         slot0_in.run_last  = (n_res == 2'd1);
         slot0_in.text_done = (n_res == 2'd1) && req_text_end;
         slot1_in.out_byte  = byte1;
         slot1_in.run_last  = 1'b1;
         slot1_in.text_done = req_text_end;
      end else if (pop) begin
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= bee_pkg::MODE_PLAIN;
         nib_ff   <= 4'd0;
         count_ff <= 2'd0;
      end else begin
         if (accept) begin
            mode_ff <= mode_in;
            nib_ff  <= nib_in;
         end
         count_ff <= count_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   // buffer never holds more than two results
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer over two entries");

   // an accepted item loads exactly its own result count
   a_count_load: assert property (@(posedge clock) disable iff (reset)
      accept |=> count_ff == $past(n_res))
      else $error("result count mismatch after accept");

   // a final byte always leaves the decoder in plain mode
   a_end_plain: assert property (@(posedge clock) disable iff (reset)
      accept && req_text_end |=> mode_ff == bee_pkg::MODE_PLAIN)
      else $error("escape state not cleared at end of text");

   // a final byte always produces at least one result
   a_end_result: assert property (@(posedge clock) disable iff (reset)
      accept && req_text_end |=> rsp_valid)
      else $error("final byte gave no result");

   // input is held off only while results remain buffered
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> count_ff != 2'd0)
      else $error("input stalled with empty buffer");

endmodule
`default_nettype wire
